>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks, the decoder top level.
// No dependencies; each macro takes a label, clock, active-low reset and two terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

>>> hw/rtl/nvd_pkg.sv
// Types and constants for the nibble varint decoder.
// No dependencies; used by the core and the top level.
package nvd_pkg;

    typedef enum logic [2:0] {
        PH_FIRST    = 3'd0,
        PH_SIX      = 3'd1,
        PH_NINE     = 3'd2,
        PH_TWELVE   = 3'd3,
        PH_COUNTED  = 3'd4,
        PH_PREFIXED = 3'd5
    } phase_t;

    // Leading nibble codes
    localparam logic [3:0] NIB_LIT_MAX  = 4'h6;
    localparam logic [3:0] NIB_NEST     = 4'h7;
    localparam logic [3:0] NIB_SIX_MAX  = 4'hB;
    localparam logic [3:0] NIB_NINE_MAX = 4'hD;
    localparam logic [3:0] NIB_TWELVE   = 4'hE;

    localparam logic [31:0] COUNT_MAX = 32'd8;

    localparam logic [5:0] LEN_NONE   = 6'd0;
    localparam logic [5:0] LEN_LIT    = 6'd3;
    localparam logic [5:0] LEN_SIX    = 6'd6;
    localparam logic [5:0] LEN_NINE   = 6'd9;
    localparam logic [5:0] LEN_TWELVE = 6'd12;
    localparam logic [5:0] LEN_WORD   = 6'd32;

    typedef struct packed {
        logic [3:0] nibble;
        logic       mode;
        logic       src_end;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         bit_length;
        logic               error;
    } out_item_t;

endpackage

>>> hw/rtl/nvd_in_if.sv
// Input channel of the decoder: valid/ready plus one nibble item.
// No dependencies; its payload fields mirror the widths of nvd_pkg's in_item_t.
interface nvd_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       mode;
    logic       src_end;

    modport source (output valid, output nibble, output mode, output src_end, input ready);
    modport sink   (input valid, input nibble, input mode, input src_end, output ready);
endinterface

>>> hw/rtl/nvd_out_if.sv
// Result channel of the decoder: valid/ready plus one decoded value item.
// No dependencies; its payload fields mirror the widths of nvd_pkg's out_item_t.
interface nvd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [5:0]         bit_length;
    logic               error;

    modport source (output valid, output value, output bit_length, output error, input ready);
    modport sink   (input valid, input value, input bit_length, input error, output ready);
endinterface

>>> hw/rtl/nvd_core.sv
// Decoder state and combinational step logic, registered on each fire: one nibble item per fire.
// Depends on nvd_pkg.
module nvd_core
    import nvd_pkg::*;
#(
    parameter int NEST_MAX = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    output logic      res_vld,
    output out_item_t res
);

    localparam int PW = $clog2(NEST_MAX + 1);

    phase_t          phase_reg, phase_next;
    logic [31:0]     acc_reg, acc_next;
    logic [3:0]      dig_reg, dig_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [PW-1:0]   pend_reg, pend_next;
    logic            sgn_reg, sgn_next;
    logic            err_reg, err_next;

    logic            busy;
    logic [5:0]      phase_len;
    logic [31:0]     acc_sh;
    logic [3:0]      dig_dec;
    logic            fin;
    logic [31:0]     fin_v;
    logic [5:0]      fin_len;
    logic [PW-1:0]   pend_eff;
    logic            from_end;
    logic            cnt_ok;

    function automatic logic [31:0] sext(input logic [31:0] v, input logic [5:0] len,
                                         input logic sgn);
        logic [4:0]  top;
        logic [31:0] r;
        top = 5'(len - 6'd1);
        r   = v;
        if (sgn && (len != LEN_NONE) && (len < LEN_WORD) && v[top])
            r = v | (32'hFFFF_FFFF << len);
        return r;
    endfunction

    assign busy = (phase_reg inside {PH_SIX, PH_NINE, PH_TWELVE, PH_COUNTED});

    always_comb
    begin
        case (phase_reg)
            PH_SIX:    phase_len = LEN_SIX;
            PH_NINE:   phase_len = LEN_NINE;
            PH_TWELVE: phase_len = LEN_TWELVE;
            default:   phase_len = {cnt_reg, 2'b00};
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        sgn_next   = sgn_reg;
        err_next   = err_reg;
        res_vld    = 1'b0;
        res        = '0;
        fin        = 1'b0;
        fin_v      = '0;
        fin_len    = LEN_NONE;
        pend_eff   = pend_reg;
        from_end   = 1'b0;
        acc_sh     = {acc_reg[27:0], item.nibble};
        dig_dec    = (dig_reg != 4'd0) ? dig_reg - 4'd1 : 4'd0;

        if (!item.src_end) begin
            if (busy) begin
                acc_next = acc_sh;
                dig_next = dig_dec;
                if (dig_dec == 4'd0) begin
                    fin     = 1'b1;
                    fin_v   = acc_sh;
                    fin_len = phase_len;
                end
            end else begin
                if (phase_reg != PH_PREFIXED && pend_reg == '0)
                    sgn_next = item.mode;
                if (item.nibble <= NIB_LIT_MAX) begin
                    fin     = 1'b1;
                    fin_v   = {28'd0, item.nibble};
                    fin_len = LEN_LIT;
                end else if (item.nibble == NIB_NEST) begin
                    if (pend_reg >= PW'(NEST_MAX)) begin
                        // nesting overflow: the whole value ends as zero
                        err_next = 1'b1;
                        pend_eff = '0;
                        fin      = 1'b1;
                    end else begin
                        pend_next  = pend_reg + PW'(1);
                        phase_next = PH_FIRST;
                    end
                end else if (item.nibble <= NIB_SIX_MAX) begin
                    acc_next   = {30'd0, item.nibble[1:0]};
                    dig_next   = 4'd1;
                    phase_next = PH_SIX;
                end else if (item.nibble <= NIB_NINE_MAX) begin
                    acc_next   = {31'd0, item.nibble[0]};
                    dig_next   = 4'd2;
                    phase_next = PH_NINE;
                end else if (item.nibble == NIB_TWELVE) begin
                    acc_next   = '0;
                    dig_next   = 4'd3;
                    phase_next = PH_TWELVE;
                end else begin
                    phase_next = PH_PREFIXED;
                end
            end
        end else if (phase_reg != PH_FIRST || pend_reg != '0) begin
            // source exhausted mid-value: pad with zero nibbles
            err_next = 1'b1;
            from_end = 1'b1;
            fin      = 1'b1;
            if (busy) begin
                fin_v   = (dig_reg[3]) ? 32'd0 : (acc_reg << {dig_reg[2:0], 2'b00});
                fin_len = phase_len;
            end else begin
                fin_v   = '0;
                fin_len = LEN_LIT;
            end
        end

        cnt_ok = (fin_v != 32'd0) && (fin_v <= COUNT_MAX);

        if (fin) begin
            if (pend_eff != '0 && cnt_ok && !from_end) begin
                // value becomes the count of an enclosing 7
                phase_next = PH_COUNTED;
                dig_next   = fin_v[3:0];
                cnt_next   = fin_v[3:0];
                acc_next   = '0;
                pend_next  = pend_eff - PW'(1);
            end else begin
                res_vld = 1'b1;
                res.error = err_next;
                if (pend_eff != '0) begin
                    if (!cnt_ok && fin_v != 32'd0)
                        err_next = 1'b1;
                    res.error      = err_next;
                    res.value      = '0;
                    // padded counted value at the outermost level keeps its length
                    if (from_end && cnt_ok && pend_eff == PW'(1))
                        res.bit_length = {fin_v[3:0], 2'b00};
                    else
                        res.bit_length = LEN_NONE;
                end else begin
                    res.value      = sext(fin_v, fin_len, sgn_next);
                    res.bit_length = fin_len;
                end
                phase_next = PH_FIRST;
                acc_next   = '0;
                dig_next   = '0;
                cnt_next   = '0;
                pend_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_FIRST;
            acc_reg   <= '0;
            dig_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= '0;
            sgn_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dig_reg   <= dig_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            sgn_reg   <= sgn_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> hw/rtl/nibble_varint_decoder_top.sv
// Nibble varint decoder, top level. An accepted item waits in the input register; the item that
// completes a value then decodes into the result register, which drives result.valid.
// Throughput: one nibble item per cycle while the result register is free or draining;
// a stalled result register holds the input register, which then backs up the input.
// Reset (rst_n, async, active low) clears valids, decoder state and the sticky error.
// Depends on nvd_pkg, nvd_in_if, nvd_out_if, nvd_core and assert_macros.svh.
`include "assert_macros.svh"

module nibble_varint_decoder_top
    import nvd_pkg::*;
#(
    parameter int NEST_MAX = 16
)
(
    input logic       clk,
    input logic       rst_n,
    nvd_in_if.sink    stream,
    nvd_out_if.source result
);

    // Input register: one item waiting for the decode step.
    logic      in_vld_reg;
    in_item_t  in_reg;

    // Result register: decoupled from the input side by the fire term below.
    logic      out_vld_reg;
    out_item_t out_reg;

    logic      fire;
    logic      core_res_vld;
    out_item_t core_res;
    in_item_t  stream_item;

    assign stream_item = '{nibble: stream.nibble, mode: stream.mode, src_end: stream.src_end};

    // The held item decodes when the result slot is free or draining this cycle.
    assign fire         = in_vld_reg && (!out_vld_reg || result.ready);
    assign stream.ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (stream.ready) begin
            in_vld_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
            in_reg <= stream_item;
    end

    nvd_core #(
        .NEST_MAX (NEST_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .item    (in_reg),
        .res_vld (core_res_vld),
        .res     (core_res)
    );

    // Items that finish no value (prefixes, leading digits) do not load the result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (fire && core_res_vld) begin
            out_vld_reg <= 1'b1;
        end else if (result.ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && core_res_vld)
            out_reg <= core_res;
    end

    assign result.valid      = out_vld_reg;
    assign result.value      = out_reg.value;
    assign result.bit_length = out_reg.bit_length;
    assign result.error      = out_reg.error;

    // A decoded value always lands in the result register.
    `ASSERT_NEXT(a_res_load, clk, rst_n, fire && core_res_vld, out_vld_reg)
    // A held item that cannot decode stays held.
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_reg && !fire, in_vld_reg)
    // The error flag never drops once a result has shown it.
    `ASSERT_NEXT(a_err_sticky, clk, rst_n,
        out_vld_reg && out_reg.error && fire && core_res_vld, out_reg.error)

endmodule
